/* hdl/ebn_pkg.sv */
// Shared types, constants and tables of the ERB band and bin feature normalizer.
package ebn_pkg;

    localparam int BINS        = 481;
    localparam int BANDS       = 32;
    localparam int DF_BINS_DEF = 96;

    localparam int BIN_W  = 9;
    localparam int BAND_W = 5;
    localparam int FILL_W = 7;
    localparam int SMP_W  = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SMOOTHING = 2'd0;
    localparam logic [1:0] REG_DIVISOR   = 2'd1;
    localparam logic [1:0] REG_LOG_EN    = 2'd2;

    localparam logic [15:0] SMOOTHING_RST = 16'd64880;
    localparam logic [7:0]  DIVISOR_RST   = 8'd40;
    localparam logic        LOG_EN_RST    = 1'b1;

    localparam logic signed [SMP_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [SMP_W-1:0] SAT_MIN = 24'sh800000;

    // 1e-10 in Q2.46 and 10*log10(2) in Q2.28
    localparam logic [63:0] DB_EPS      = 64'd7037;
    localparam logic [30:0] TEN_LOG10_2 = 31'd808071242;

    // Bins per ERB band, lowest band first
    localparam logic [FILL_W-1:0] BAND_WIDTH [BANDS] = '{
        7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,
        7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd5,  7'd5,  7'd7,
        7'd7,  7'd8,  7'd10, 7'd12, 7'd13, 7'd15, 7'd18, 7'd20,
        7'd24, 7'd28, 7'd31, 7'd37, 7'd42, 7'd50, 7'd56, 7'd67
    };

    // One classified bin, handed from the front end to the datapath
    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        logic                    restart;
        logic                    fend;
        logic                    wrap_clear;
        logic                    do_bin;
        logic [BIN_W-1:0]        bin_idx;
        logic                    band_close;
        logic [BAND_W-1:0]       band_idx;
        logic [FILL_W-1:0]       width;
    } job_t;

endpackage

/* hdl/ebn_ram.sv */
// Generic single-port-write, registered-read RAM.
module ebn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/ebn_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
module ebn_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [49:0] radicand,
    output logic [24:0] root,
    output logic        done
);

    logic [49:0] src_reg, src_next;
    logic [25:0] rem_reg, rem_next;
    logic [24:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [27:0] rem_sh;
    logic [27:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg, src_reg[49:48]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    // Bring down two radicand bits, try the next root bit
    always_comb begin
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            src_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next  = {src_reg[47:0], 2'b00};
            rem_next  = ge ? 26'(rem_sh - trial) : rem_sh[25:0];
            root_next = {root_reg[23:0], ge};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* hdl/ebn_div.sv */
// Iterative restoring divider, 57-bit dividend by 25-bit divisor, one bit per cycle.
module ebn_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [56:0] dividend,
    input  logic [24:0] divisor,
    output logic [56:0] quotient,
    output logic        done
);

    logic [56:0] dvd_reg, dvd_next;
    logic [24:0] dsr_reg, dsr_next;
    logic [24:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, dvd_reg[56]};
    assign ge     = (rem_sh >= {1'b0, dsr_reg});

    // Shift in one dividend bit, subtract where it fits, shift the quotient bit in
    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[55:0], ge};
            rem_next = ge ? 25'(rem_sh - {1'b0, dsr_reg}) : rem_sh[24:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd56) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

/* hdl/ebn_fifo.sv */
// Short request queue between the front end and the datapath.
module ebn_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ebn_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output ebn_pkg::job_t rd_job,
    output logic          empty
);

    ebn_pkg::job_t                  mem_reg [ebn_pkg::QUEUE_DEPTH];
    logic [ebn_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ebn_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ebn_pkg::QPTR_W:0]       count_reg, count_next;

    assign full   = (count_reg == (ebn_pkg::QPTR_W+1)'(ebn_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

/* hdl/ebn_front.sv */
// Front end: accepts bins, tracks bin/band position and classifies each request.
module ebn_front #(
    parameter int DF_BINS = ebn_pkg::DF_BINS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [47:0]              s_tdata,
    input  logic                     s_tlast,
    input  logic                     s_tuser,
    input  logic                     q_full,
    output logic                     q_push,
    output ebn_pkg::job_t            q_job
);

    logic [ebn_pkg::BIN_W-1:0]  bin_pos_reg, bin_pos_next;
    logic [ebn_pkg::BAND_W-1:0] band_pos_reg, band_pos_next;
    logic [ebn_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [ebn_pkg::FILL_W-1:0] width;
    logic [ebn_pkg::FILL_W-1:0] fill_inc;
    logic                       close;
    logic                       wrap;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Classify the bin against the band table
    assign width    = ebn_pkg::BAND_WIDTH[band_pos_reg];
    assign fill_inc = fill_reg + 1'b1;
    assign close    = (fill_inc >= width);
    assign wrap     = s_tlast || (bin_pos_reg == ebn_pkg::BIN_W'(ebn_pkg::BINS - 1));

    always_comb begin
        q_job.re         = s_tdata[23:0];
        q_job.im         = s_tdata[47:24];
        q_job.restart    = s_tuser;
        q_job.fend       = s_tlast;
        q_job.wrap_clear = wrap;
        q_job.do_bin     = (bin_pos_reg < ebn_pkg::BIN_W'(DF_BINS));
        q_job.bin_idx    = bin_pos_reg;
        q_job.band_close = close;
        q_job.band_idx   = band_pos_reg;
        q_job.width      = width;
    end

    // Advance positions; frame end or last bin returns all to zero
    always_comb begin
        bin_pos_next  = bin_pos_reg;
        band_pos_next = band_pos_reg;
        fill_next     = fill_reg;
        if (q_push) begin
            if (wrap) begin
                bin_pos_next  = '0;
                band_pos_next = '0;
                fill_next     = '0;
            end else begin
                bin_pos_next = bin_pos_reg + 1'b1;
                if (close) begin
                    band_pos_next = (band_pos_reg == ebn_pkg::BAND_W'(ebn_pkg::BANDS - 1)) ?
                                    '0 : band_pos_reg + 1'b1;
                    fill_next     = '0;
                end else begin
                    fill_next = fill_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_pos_reg  <= '0;
            band_pos_reg <= '0;
            fill_reg     <= '0;
        end else begin
            bin_pos_reg  <= bin_pos_next;
            band_pos_reg <= band_pos_next;
            fill_reg     <= fill_next;
        end
    end

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (bin_pos_reg == '0) |-> (band_pos_reg == '0 && fill_reg == '0))
        else $error("band position not at zero at frame start");

endmodule

/* hdl/ebn_back.sv */
// Datapath sequencer: power, band sums, dB, smoothing states and normalization.
module ebn_back #(
    parameter int DF_BINS = ebn_pkg::DF_BINS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ebn_pkg::job_t q_job,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic [15:0]   alpha,
    input  logic [7:0]    norm_div,
    input  logic          log_en,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int BIN_AW = (DF_BINS > 1) ? $clog2(DF_BINS) : 1;
    localparam int ND     = (DF_BINS > 1) ? DF_BINS - 1 : 1;
    localparam int NB     = ebn_pkg::BANDS - 1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SQ_RE    = 5'd1;
    localparam logic [4:0] S_SQ_IM    = 5'd2;
    localparam logic [4:0] S_ACC      = 5'd3;
    localparam logic [4:0] S_MAG      = 5'd4;
    localparam logic [4:0] S_SMUL     = 5'd5;
    localparam logic [4:0] S_SUPD     = 5'd6;
    localparam logic [4:0] S_ROOT     = 5'd7;
    localparam logic [4:0] S_DIV_RE   = 5'd8;
    localparam logic [4:0] S_DIV_IM   = 5'd9;
    localparam logic [4:0] S_BIN_OUT  = 5'd10;
    localparam logic [4:0] S_MEAN     = 5'd11;
    localparam logic [4:0] S_MEAN_W   = 5'd12;
    localparam logic [4:0] S_NORM     = 5'd13;
    localparam logic [4:0] S_LOG      = 5'd14;
    localparam logic [4:0] S_LGMUL    = 5'd15;
    localparam logic [4:0] S_LGRND    = 5'd16;
    localparam logic [4:0] S_BSMUL    = 5'd17;
    localparam logic [4:0] S_BSUPD    = 5'd18;
    localparam logic [4:0] S_FEAT     = 5'd19;
    localparam logic [4:0] S_BAND_OUT = 5'd20;
    localparam logic [4:0] S_DONE     = 5'd21;

    // Saturate a sign-magnitude quotient to 24 bits
    function automatic logic [23:0] sat_sm(input logic [56:0] q, input logic neg);
        logic [23:0] r;
        if (neg) begin
            r = (q > 57'd8388608) ? ebn_pkg::SAT_MIN : 24'(57'd0 - q);
        end else begin
            r = (q > 57'd8388607) ? ebn_pkg::SAT_MAX : q[23:0];
        end
        return r;
    endfunction

    logic [4:0]               state_reg, state_next;
    ebn_pkg::job_t            job_reg;
    logic [47:0]              prod_reg, pwr_reg;
    logic [55:0]              sum_reg;
    logic [25:0]              s_old_reg;
    logic signed [23:0]       st_old_reg;
    logic [24:0]              mag_reg, r_reg;
    logic [41:0]              pa_reg, pb_reg;
    logic [23:0]              fr_reg, fi_reg;
    logic signed [23:0]       xs_reg;
    logic [63:0]              norm_reg;
    logic [5:0]               pexp_reg;
    logic [30:0]              m_reg;
    logic [19:0]              frac_reg;
    logic [4:0]               lcnt_reg;
    logic signed [57:0]       db_prod_reg;
    logic signed [42:0]       qa_reg, qb_reg;
    logic                     diff_neg_reg;
    logic [DF_BINS-1:0]       bin_vld_reg;
    logic [ebn_pkg::BANDS-1:0] band_vld_reg;
    logic                     m_valid_reg;
    logic                     m_kind_reg, m_last_reg;
    logic [8:0]               m_index_reg;
    logic [23:0]              m_real_reg, m_imag_reg;

    logic [25:0]              bin_ramp  [DF_BINS];
    logic signed [23:0]       band_ramp [ebn_pkg::BANDS];

    // Reset ramps of the two smoothing states
    for (genvar gi = 0; gi < DF_BINS; gi++) begin : g_bin_ramp
        localparam int RV = 16777 - (15099 * gi + ND / 2) / ND;
        assign bin_ramp[gi] = 26'(RV);
    end
    for (genvar gb = 0; gb < ebn_pkg::BANDS; gb++) begin : g_band_ramp
        localparam int BV = -3932160 - (1966080 * gb + NB / 2) / NB;
        assign band_ramp[gb] = 24'(BV);
    end

    logic [BIN_AW-1:0]        bin_addr;
    logic [4:0]               band_addr;
    logic [25:0]              bin_rdata;
    logic [23:0]              band_rdata;
    logic                     bin_we, band_we;
    logic [25:0]              s_new;
    logic [23:0]              st_new;

    logic                     sq_start, sq_done;
    logic [49:0]              sq_in;
    logic [24:0]              sq_root;
    logic                     dv_start, dv_done;
    logic [56:0]              dv_dvd, dv_q;
    logic [24:0]              dv_dsr;

    logic signed [47:0]       sq_re, sq_im;
    logic [23:0]              re_mag, im_mag;
    logic [42:0]              s_sum;
    logic signed [42:0]       st_sum;
    logic [42:0]              st_abs;
    logic [26:0]              st_q;
    logic signed [24:0]       diff;
    logic [24:0]              diff_mag;
    logic [7:0]               divd;
    logic [57:0]              lin_t;
    logic [61:0]              lg_sq;
    logic [31:0]              lg_t;
    logic signed [6:0]        lg_e;
    logic signed [26:0]       lg;
    logic [57:0]              db_abs;
    logic [25:0]              db_q;
    logic signed [26:0]       db_s;
    logic                     slot_free;
    logic                     out_load;
    logic                     out_kind, out_last;
    logic [8:0]               out_index;
    logic [23:0]              out_real, out_imag;

    assign bin_addr  = job_reg.bin_idx[BIN_AW-1:0];
    assign band_addr = job_reg.band_idx;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign slot_free = !m_valid_reg || m_tready;
    assign divd      = (norm_div == 8'd0) ? 8'd1 : norm_div;

    ebn_ram #(.WIDTH(26), .DEPTH(DF_BINS)) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_we),
        .waddr (bin_addr),
        .wdata (s_new),
        .re    (q_pop),
        .raddr (q_job.bin_idx[BIN_AW-1:0]),
        .rdata (bin_rdata)
    );

    ebn_ram #(.WIDTH(24), .DEPTH(ebn_pkg::BANDS)) u_band_ram (
        .aclk  (aclk),
        .we    (band_we),
        .waddr (band_addr),
        .wdata (st_new),
        .re    (q_pop),
        .raddr (q_job.band_idx),
        .rdata (band_rdata)
    );

    ebn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .root     (sq_root),
        .done     (sq_done)
    );

    ebn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_dvd),
        .divisor  (dv_dsr),
        .quotient (dv_q),
        .done     (dv_done)
    );

    // Arithmetic between registers
    always_comb begin
        sq_re    = job_reg.re * job_reg.re;
        sq_im    = job_reg.im * job_reg.im;
        re_mag   = job_reg.re[23] ? 24'(24'd0 - job_reg.re) : job_reg.re;
        im_mag   = job_reg.im[23] ? 24'(24'd0 - job_reg.im) : job_reg.im;
        s_sum    = {1'b0, pa_reg} + {1'b0, pb_reg} + 43'd32768;
        s_new    = s_sum[41:16];
        st_sum   = qa_reg + qb_reg;
        st_abs   = st_sum[42] ? 43'(43'd0 - st_sum) : st_sum;
        st_q     = 27'((st_abs + 43'd32768) >> 16);
        st_new   = st_sum[42] ? 24'(27'd0 - st_q) : st_q[23:0];
        diff     = 25'(xs_reg) - 25'(signed'(st_new));
        diff_mag = diff[24] ? 25'(25'd0 - diff) : diff;
        lin_t    = {1'b0, dv_q} + 58'(1 << 29);
        lg_sq    = m_reg * m_reg;
        lg_t     = lg_sq[61:30];
        lg_e     = $signed({1'b0, pexp_reg}) - 7'sd46;
        lg       = {lg_e, frac_reg};
        db_abs   = db_prod_reg[57] ? 58'(58'd0 - db_prod_reg) : db_prod_reg;
        db_q     = 26'((db_abs + 58'(32'h8000_0000)) >> 32);
        db_s     = db_prod_reg[57] ? 27'(27'd0 - db_q) : 27'(db_q);
    end

    // Unit starts and state writes
    always_comb begin
        sq_start = 1'b0;
        sq_in    = {pwr_reg, 2'b00};
        dv_start = 1'b0;
        dv_dvd   = 57'({re_mag, 21'd0}) + 57'(sq_root >> 1);
        dv_dsr   = sq_root;
        bin_we   = 1'b0;
        band_we  = 1'b0;
        case (state_reg)
            S_ACC: begin
                sq_start = job_reg.do_bin;
            end
            S_SUPD: begin
                sq_start = 1'b1;
                sq_in    = {s_new, 24'd0};
                bin_we   = 1'b1;
            end
            S_ROOT: begin
                dv_start = sq_done;
            end
            S_DIV_RE: begin
                dv_start = dv_done;
                dv_dvd   = 57'({im_mag, 21'd0}) + 57'(r_reg >> 1);
                dv_dsr   = r_reg;
            end
            S_MEAN: begin
                dv_start = 1'b1;
                dv_dvd   = {1'b0, sum_reg} + 57'(job_reg.width >> 1);
                dv_dsr   = 25'(job_reg.width);
            end
            S_BSUPD: begin
                band_we  = 1'b1;
                dv_start = 1'b1;
                dv_dvd   = 57'({diff_mag, 4'd0}) + 57'(divd >> 1);
                dv_dsr   = 25'(divd);
            end
            default: begin
            end
        endcase
    end

    // Result selection for the output register
    always_comb begin
        out_load  = 1'b0;
        out_kind  = 1'b0;
        out_last  = job_reg.fend;
        out_index = job_reg.bin_idx;
        out_real  = fr_reg;
        out_imag  = fi_reg;
        if (state_reg == S_BIN_OUT) begin
            out_load = slot_free;
            out_last = job_reg.fend && !job_reg.band_close;
        end else if (state_reg == S_BAND_OUT) begin
            out_load  = slot_free;
            out_kind  = 1'b1;
            out_index = 9'(job_reg.band_idx);
            out_imag  = '0;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (!q_empty) state_next = S_SQ_RE;
            S_SQ_RE:    state_next = S_SQ_IM;
            S_SQ_IM:    state_next = S_ACC;
            S_ACC: begin
                if (job_reg.do_bin) state_next = S_MAG;
                else if (job_reg.band_close) state_next = S_MEAN;
                else state_next = S_DONE;
            end
            S_MAG:      if (sq_done) state_next = S_SMUL;
            S_SMUL:     state_next = S_SUPD;
            S_SUPD:     state_next = S_ROOT;
            S_ROOT:     if (sq_done) state_next = S_DIV_RE;
            S_DIV_RE:   if (dv_done) state_next = S_DIV_IM;
            S_DIV_IM:   if (dv_done) state_next = S_BIN_OUT;
            S_BIN_OUT: begin
                if (slot_free) state_next = job_reg.band_close ? S_MEAN : S_DONE;
            end
            S_MEAN:     state_next = S_MEAN_W;
            S_MEAN_W:   if (dv_done) state_next = log_en ? S_NORM : S_BSMUL;
            S_NORM:     if (norm_reg[63]) state_next = S_LOG;
            S_LOG:      if (lcnt_reg == 5'd19) state_next = S_LGMUL;
            S_LGMUL:    state_next = S_LGRND;
            S_LGRND:    state_next = S_BSMUL;
            S_BSMUL:    state_next = S_BSUPD;
            S_BSUPD:    state_next = S_FEAT;
            S_FEAT:     if (dv_done) state_next = S_BAND_OUT;
            S_BAND_OUT: if (slot_free) state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            bin_vld_reg  <= '0;
            band_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop && q_job.restart) begin
                bin_vld_reg  <= '0;
                band_vld_reg <= '0;
            end else begin
                if (bin_we) bin_vld_reg[bin_addr] <= 1'b1;
                if (band_we) band_vld_reg[band_addr] <= 1'b1;
            end
            if (state_reg == S_ACC) begin
                sum_reg <= sum_reg + {8'd0, pwr_reg};
            end else if (state_reg == S_DONE && (job_reg.band_close || job_reg.wrap_clear)) begin
                sum_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) job_reg <= q_job;
        if (state_reg == S_SQ_RE) prod_reg <= 48'(sq_re);
        if (state_reg == S_SQ_IM) pwr_reg <= prod_reg + 48'(sq_im);
        if (state_reg == S_ACC) begin
            s_old_reg  <= bin_vld_reg[bin_addr] ? bin_rdata : bin_ramp[bin_addr];
            st_old_reg <= band_vld_reg[band_addr] ? band_rdata : band_ramp[band_addr];
        end
        if (state_reg == S_MAG && sq_done) mag_reg <= sq_root;
        if (state_reg == S_SMUL) begin
            pa_reg <= 42'(alpha * s_old_reg);
            pb_reg <= 42'((17'h10000 - {1'b0, alpha}) * mag_reg);
        end
        if (state_reg == S_ROOT && sq_done) r_reg <= sq_root;
        if (state_reg == S_DIV_RE && dv_done) begin
            fr_reg <= (r_reg == '0 && job_reg.re == '0) ? '0 : sat_sm(dv_q, job_reg.re[23]);
        end
        if (state_reg == S_DIV_IM && dv_done) begin
            fi_reg <= (r_reg == '0 && job_reg.im == '0) ? '0 : sat_sm(dv_q, job_reg.im[23]);
        end
        if (state_reg == S_MEAN_W && dv_done) begin
            norm_reg <= 64'(dv_q) + ebn_pkg::DB_EPS;
            pexp_reg <= 6'd63;
            xs_reg   <= (lin_t[57:30] > 28'd8388607) ? ebn_pkg::SAT_MAX : lin_t[53:30];
        end
        if (state_reg == S_NORM) begin
            if (norm_reg[63:56] == 8'd0) begin
                norm_reg <= {norm_reg[55:0], 8'd0};
                pexp_reg <= pexp_reg - 6'd8;
            end else if (!norm_reg[63]) begin
                norm_reg <= {norm_reg[62:0], 1'b0};
                pexp_reg <= pexp_reg - 6'd1;
            end
            m_reg    <= norm_reg[63:33];
            frac_reg <= '0;
            lcnt_reg <= '0;
        end
        if (state_reg == S_LOG) begin
            m_reg    <= lg_t[31] ? lg_t[31:1] : lg_t[30:0];
            frac_reg <= {frac_reg[18:0], lg_t[31]};
            lcnt_reg <= lcnt_reg + 5'd1;
        end
        if (state_reg == S_LGMUL) db_prod_reg <= 58'(lg * $signed({1'b0, ebn_pkg::TEN_LOG10_2}));
        if (state_reg == S_LGRND) begin
            if (db_s > 27'sd8388607) xs_reg <= ebn_pkg::SAT_MAX;
            else if (db_s < -27'sd8388608) xs_reg <= ebn_pkg::SAT_MIN;
            else xs_reg <= db_s[23:0];
        end
        if (state_reg == S_BSMUL) begin
            qa_reg <= 43'($signed({1'b0, alpha}) * st_old_reg);
            qb_reg <= 43'($signed({1'b0, 17'h10000 - {1'b0, alpha}}) * xs_reg);
        end
        if (state_reg == S_BSUPD) diff_neg_reg <= diff[24];
        if (state_reg == S_FEAT && dv_done) fr_reg <= sat_sm(dv_q, diff_neg_reg);
        if (out_load) begin
            m_kind_reg  <= out_kind;
            m_last_reg  <= out_last;
            m_index_reg <= out_index;
            m_real_reg  <= out_real;
            m_imag_reg  <= out_imag;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_imag_reg, m_real_reg, m_index_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_BIN_OUT ||
                                $past(state_reg) == S_BAND_OUT))
        else $error("result raised outside an output step");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == S_SQ_RE))
        else $error("request taken but sequencer did not start");

endmodule

/* hdl/erb_band_and_bin_feature_norm_core.sv */
// Top level of the ERB band energy and complex bin feature normalizer.
//
//  port group  | direction | contents
//  s_*         | in        | one spectrum bin per request, tlast = frame end, tuser = restart
//  m_*         | out       | zero to two features per request, tuser = kind, tlast = frame last
//  cfg_*       | in        | register writes: smoothing factor, divisor, log enable
//
// A bin below DF_BINS runs two 25-step square roots and two 57-step divisions.
// A bin that closes a band adds two more 57-step divisions in linear mode, and in
// dB mode also the normalize shift and 20 squaring steps of the log. Other bins
// only add their power to the band sum.
// Reset is synchronous, active low; smoothing states read as their ramps until written.
// A four-entry queue lets input requests be taken while the datapath or the output stalls.
module erb_band_and_bin_feature_norm_core #(
    parameter int DF_BINS = ebn_pkg::DF_BINS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bin_real [23:0], bin_imag [47:24]
    input  logic        s_tlast,
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // feature_index [8:0], feature_real [32:9], feature_imag [56:33]
    output logic        m_tuser,   // feature_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]   alpha_reg;
    logic [7:0]    divisor_reg;
    logic          log_en_reg;
    logic          q_full, q_empty, q_push, q_pop;
    ebn_pkg::job_t wr_job, rd_job;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= ebn_pkg::SMOOTHING_RST;
            divisor_reg <= ebn_pkg::DIVISOR_RST;
            log_en_reg  <= ebn_pkg::LOG_EN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ebn_pkg::REG_SMOOTHING: alpha_reg   <= cfg_wdata;
                ebn_pkg::REG_DIVISOR:   divisor_reg <= cfg_wdata[7:0];
                ebn_pkg::REG_LOG_EN:    log_en_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    ebn_front #(.DF_BINS(DF_BINS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (wr_job)
    );

    ebn_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (wr_job),
        .full    (q_full),
        .pop     (q_pop),
        .rd_job  (rd_job),
        .empty   (q_empty)
    );

    ebn_back #(.DF_BINS(DF_BINS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (rd_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .alpha    (alpha_reg),
        .norm_div (divisor_reg),
        .log_en   (log_en_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
